// File: sv/mcp0_pkg.sv
package mcp0_pkg;

	// register file geometry
	localparam int RegCount = 32;
	localparam int RegAw    = $clog2(RegCount);

	// special registers
	localparam logic [4:0] RegBadv  = 5'd8;
	localparam logic [4:0] RegSr    = 5'd12;
	localparam logic [4:0] RegCause = 5'd13;
	localparam logic [4:0] RegEpc   = 5'd14;

	// exception codes
	localparam logic [4:0] ExcInt  = 5'd0;
	localparam logic [4:0] ExcAdel = 5'd4;
	localparam logic [4:0] ExcAdes = 5'd5;
	localparam logic [4:0] ExcSys  = 5'd8;
	localparam logic [4:0] ExcBp   = 5'd9;
	localparam logic [4:0] ExcOv   = 5'd12;

	localparam logic [31:0] ExcVector = 32'h8000_0080;

	// sr and cause bits
	localparam int SrIec   = 0;
	localparam int SrIm2   = 10;
	localparam int SrIsc   = 16;
	localparam int SrBev   = 22;
	localparam int CauseIp2 = 10;
	localparam int CauseBd = 31;

	typedef enum logic [2:0] {
		OpRead   = 3'd0,
		OpWrite  = 3'd1,
		OpRfe    = 3'd2,
		OpExc    = 3'd3,
		OpIrqChk = 3'd4,
		OpUnsup  = 3'd5
	} op_t;

	// one input beat
	typedef struct packed {
		logic        irq_pending;
		logic [31:0] fault_address;
		logic        in_delay_slot;
		logic [31:0] branch_pc;
		logic [31:0] current_pc;
		logic [4:0]  exc_code;
		logic [31:0] write_data;
		logic [4:0]  reg_index;
		logic [2:0]  opcode;
	} mcp0_item_t;

	// one result beat
	typedef struct packed {
		logic        halt_unsupported;
		logic        isolate_cache;
		logic [31:0] redirect_pc;
		logic        redirect;
		logic [31:0] read_data;
	} mcp0_result_t;

endpackage

// File: sv/mcp0_core.sv
module mcp0_core import mcp0_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         fire,
	input  mcp0_item_t   item,
	output mcp0_result_t result
);

	typedef struct packed {
		logic [31:0] sr;
		logic [31:0] cause;
		logic        epc_we;
		logic [31:0] epc;
		logic        badv_we;
		logic [31:0] badv;
	} exc_upd_t;

	logic [31:0] regs_q [RegCount];
	logic        iso_q;

	// exception entry: push mode stack, record code, and for the codes that need them, epc and bad address
	function automatic exc_upd_t exc_entry(input logic [4:0] code, input logic [31:0] pc,
			input logic [31:0] bpc, input logic slot, input logic [31:0] faddr,
			input logic [31:0] sr, input logic [31:0] cause);
		exc_upd_t u;
		u.sr      = {sr[31:6], sr[3:0], 2'b00};
		u.cause   = {cause[31:7], code, 2'b00};
		u.epc_we  = 1'b0;
		u.epc     = pc - 32'd8;
		u.badv_we = (code == ExcAdel) || (code == ExcAdes);
		u.badv    = faddr;
		if ((code == ExcAdel) || (code == ExcAdes) || (code == ExcSys) ||
				(code == ExcBp) || (code == ExcOv)) begin
			u.epc_we = 1'b1;
		end
		if (code == ExcInt) begin
			u.epc_we = 1'b1;
			if (slot) begin
				u.epc            = bpc;
				u.cause[CauseBd] = 1'b1;
			end else begin
				u.epc = pc - 32'd4;
			end
		end
		return u;
	endfunction

	logic          in_range;
	logic [31:0]   rd_val;
	logic [31:0]   sr;
	logic [31:0]   cause;
	logic [31:0]   cause_irq;
	logic          irq_take;
	exc_upd_t      exc_u;
	logic          gen_we;
	logic [31:0]   gen_val;
	logic          sr_we;
	logic [31:0]   sr_d;
	logic          cause_we;
	logic [31:0]   cause_d;
	logic          epc_we;
	logic          badv_we;
	logic          iso_d;
	logic          redir;
	logic          halt;
	logic [31:0]   rdata;

	assign in_range  = {1'b0, item.reg_index} < 6'(RegCount);
	assign rd_val    = in_range ? regs_q[item.reg_index[RegAw-1:0]] : 32'd0;
	assign sr        = regs_q[RegSr[RegAw-1:0]];
	assign cause     = regs_q[RegCause[RegAw-1:0]];
	assign cause_irq = {cause[31:CauseIp2+1], item.irq_pending, cause[CauseIp2-1:0]};
	assign irq_take  = sr[SrIec] && sr[SrIm2] && item.irq_pending;

	// exception update, shared by explicit exceptions and taken interrupts
	always_comb begin
		if (op_t'(item.opcode) == OpIrqChk) begin
			exc_u = exc_entry(ExcInt, item.current_pc, item.branch_pc, item.in_delay_slot,
				item.fault_address, sr, cause_irq);
		end else begin
			exc_u = exc_entry(item.exc_code, item.current_pc, item.branch_pc,
				item.in_delay_slot, item.fault_address, sr, cause);
		end
	end

	// operation decode
	always_comb begin
		gen_we   = 1'b0;
		gen_val  = item.write_data;
		sr_we    = 1'b0;
		sr_d     = exc_u.sr;
		cause_we = 1'b0;
		cause_d  = exc_u.cause;
		epc_we   = 1'b0;
		badv_we  = 1'b0;
		iso_d    = iso_q;
		redir    = 1'b0;
		halt     = 1'b0;
		rdata    = 32'd0;
		case (op_t'(item.opcode))
			OpRead: begin
				rdata = rd_val;
			end
			OpWrite: begin
				gen_we = in_range;
				if (item.reg_index == RegCause) begin
					gen_val = {cause[31:10], item.write_data[9:8], cause[7:0]};
				end
				if (item.reg_index == RegSr) begin
					iso_d = item.write_data[SrIsc];
					halt  = item.write_data[SrBev];
				end else begin
					halt  = sr[SrBev];
				end
			end
			OpRfe: begin
				sr_we = 1'b1;
				sr_d  = {sr[31:4], sr[5:2]};
			end
			OpExc: begin
				sr_we    = 1'b1;
				cause_we = 1'b1;
				epc_we   = exc_u.epc_we;
				badv_we  = exc_u.badv_we;
				redir    = 1'b1;
			end
			OpIrqChk: begin
				cause_we = 1'b1;
				cause_d  = cause_irq;
				if (irq_take) begin
					sr_we   = 1'b1;
					cause_d = exc_u.cause;
					epc_we  = exc_u.epc_we;
					badv_we = exc_u.badv_we;
					redir   = 1'b1;
				end
			end
			default: begin
				halt = 1'b1;
			end
		endcase
	end

	// register file and isolation flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RegCount; i++) begin
				regs_q[i] <= 32'd0;
			end
			iso_q <= 1'b0;
		end else if (fire) begin
			if (gen_we) begin
				regs_q[item.reg_index[RegAw-1:0]] <= gen_val;
			end
			if (sr_we) begin
				regs_q[RegSr[RegAw-1:0]] <= sr_d;
			end
			if (cause_we) begin
				regs_q[RegCause[RegAw-1:0]] <= cause_d;
			end
			if (epc_we) begin
				regs_q[RegEpc[RegAw-1:0]] <= exc_u.epc;
			end
			if (badv_we) begin
				regs_q[RegBadv[RegAw-1:0]] <= exc_u.badv;
			end
			iso_q <= iso_d;
		end
	end

	assign result.read_data        = rdata;
	assign result.redirect         = redir;
	assign result.redirect_pc      = redir ? ExcVector : 32'd0;
	assign result.isolate_cache    = iso_d;
	assign result.halt_unsupported = halt;

endmodule

// File: sv/mips_coprocessor0_exceptions_top.sv
// System control coprocessor with exception, interrupt-check and return-from-exception
// handling. It takes one operation beat per clock while the output is not stalled, and
// returns exactly one result beat per operation, carried from the input register to the
// output register; the sustained rate is one beat per cycle, set by the single register-file
// update done in the stage between the input register and the output register. While a
// result beat waits on a stalled output, the input register can still take one more beat,
// after which s_tready stays low until the waiting result beat is taken. All 32 coprocessor
// registers and the cache isolation flag are cleared by reset.
module mips_coprocessor0_exceptions_top import mcp0_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// opcode[2:0], reg_index[7:3], write_data[39:8], exc_code[44:40], current_pc[76:45],
	// branch_pc[108:77], in_delay_slot[109], fault_address[141:110], irq_pending[142]
	input  logic [143:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// read_data[31:0], redirect[32], redirect_pc[64:33], isolate_cache[65],
	// halt_unsupported[66]
	output logic [71:0]  m_tdata
);

	mcp0_item_t   item_s1;
	logic         valid_s1;
	mcp0_result_t res;
	mcp0_result_t res_q;
	logic         m_valid_q;
	logic         advance;
	logic         s_fire;

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_fire   = s_tvalid && s_tready;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_fire) begin
			item_s1 <= mcp0_item_t'(s_tdata[142:0]);
		end
	end

	mcp0_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.result (res)
	);

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'd0, res_q};

endmodule
